/* src/odo_pkg.sv */
// odo_pkg: shared types, constants and helper functions for the odometry core.
// No dependencies; used by every module of the block.
`default_nettype none

package odo_pkg;

    localparam logic signed [35:0] PI_Q28          = 36'sd843314857;
    localparam logic signed [35:0] TWO_PI_Q28      = 36'sd1686629714;
    localparam logic signed [35:0] HALF_PI_Q28     = 36'sd421657428;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic [63:0]        LIM62           = 64'h4000_0000_0000_0000;

    localparam logic [31:0] MPT_RST = 32'd429497;
    localparam logic [23:0] ITW_RST = 24'd218453;
    localparam logic [27:0] IP_RST  = 28'd6553600;

    localparam logic [1:0] CFG_MPT = 2'd0;
    localparam logic [1:0] CFG_ITW = 2'd1;
    localparam logic [1:0] CFG_IP  = 2'd2;

    typedef struct packed {
        logic signed [31:0] dl;
        logic signed [31:0] dr;
    } delta_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [5:0]         sh;
    } mul_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [63:0] res;
    } mul_rsp_t;

    typedef struct packed {
        logic signed [31:0] speed_product;
        logic signed [31:0] ang_accel;
        logic signed [31:0] lin_accel;
        logic signed [31:0] ang_speed;
        logic signed [31:0] lin_speed;
        logic signed [30:0] heading;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } result_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'h3243F6A8;
            5'd1:  r = 32'h1DAC6705;
            5'd2:  r = 32'h0FADBAFC;
            5'd3:  r = 32'h07F56EA6;
            5'd4:  r = 32'h03FEAB76;
            5'd5:  r = 32'h01FFD55B;
            5'd6:  r = 32'h00FFFAAA;
            5'd7:  r = 32'h007FFF55;
            5'd8:  r = 32'h003FFFEA;
            5'd9:  r = 32'h001FFFFD;
            5'd10: r = 32'h000FFFFF;
            5'd11: r = 32'h0007FFFF;
            5'd12: r = 32'h0003FFFF;
            5'd13: r = 32'h0001FFFF;
            5'd14: r = 32'h0000FFFF;
            5'd15: r = 32'h00007FFF;
            5'd16: r = 32'h00003FFF;
            5'd17: r = 32'h00001FFF;
            5'd18: r = 32'h00000FFF;
            5'd19: r = 32'h000007FF;
            5'd20: r = 32'h000003FF;
            5'd21: r = 32'h000001FF;
            5'd22: r = 32'h000000FF;
            5'd23: r = 32'h0000007F;
            5'd24: r = 32'h0000003F;
            5'd25: r = 32'h0000001F;
            5'd26: r = 32'h0000000F;
            5'd27: r = 32'h00000008;
            5'd28: r = 32'h00000004;
            5'd29: r = 32'h00000002;
            5'd30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // wrap into [-pi, pi); input within +-2.5 periods
    function automatic logic signed [31:0] wrap_angle(input logic signed [35:0] v);
        logic signed [35:0] r;
        r = v + PI_Q28;
        priority if (r < -TWO_PI_Q28)      r = r + 2 * TWO_PI_Q28;
        else if (r < 36'sd0)               r = r + TWO_PI_Q28;
        else if (r >= 2 * TWO_PI_Q28)      r = r - 2 * TWO_PI_Q28;
        else if (r >= TWO_PI_Q28)          r = r - TWO_PI_Q28;
        r = r - PI_Q28;
        return r[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        priority if (v > 66'sd2147483647)   r = 32'sh7FFF_FFFF;
        else if (v < -66'sd2147483648)      r = 32'sh8000_0000;
        else                                r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/odo_queue.sv */
// odo_queue: two-entry queue of tick deltas between front and back.
// Depends on odo_pkg.
`default_nettype none

module odo_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  odo_pkg::delta_t      push_item,
    output logic                 full,
    input  wire logic            pop,
    output odo_pkg::delta_t      pop_item,
    output logic                 not_empty
);

    odo_pkg::delta_t mem [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* src/odo_front.sv */
// odo_front: accepts encoder counts, forms wrapped tick deltas, feeds the queue.
// Depends on odo_pkg.
`default_nettype none

module odo_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] left_count,
    input  wire logic signed [31:0] right_count,
    input  wire logic               q_full,
    output logic                    push,
    output odo_pkg::delta_t         push_item
);

    logic [31:0] last_left_reg;
    logic [31:0] last_right_reg;

    assign in_ready     = !q_full;
    assign push         = in_valid && !q_full;
    assign push_item.dl = left_count - last_left_reg;
    assign push_item.dr = right_count - last_right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_left_reg  <= 32'd0;
            last_right_reg <= 32'd0;
        end
        else if (push)
        begin
            last_left_reg  <= left_count;
            last_right_reg <= right_count;
        end
    end

endmodule

`default_nettype wire

/* src/odo_mul.sv */
// odo_mul: shared 64x64 signed multiply with floor shift and clamp to +-2^62.
// Four 32x32 partial products, one per cycle. Depends on odo_pkg.
`default_nettype none

module odo_mul (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  odo_pkg::mul_req_t req,
    output odo_pkg::mul_rsp_t rsp
);

    localparam logic [2:0] PH_ACC_LAST = 3'd4;
    localparam logic [2:0] PH_SHIFT    = 3'd5;
    localparam logic [2:0] PH_FIN      = 3'd6;

    logic         busy_reg;
    logic [2:0]   ph_reg;
    logic         done_reg;
    logic [63:0]  ua_reg;
    logic [63:0]  ub_reg;
    logic         neg_reg;
    logic [5:0]   sh_reg;
    logic [63:0]  prod_reg;
    logic [127:0] acc_reg;
    logic [127:0] q_reg;
    logic         rem_reg;
    logic signed [63:0] res_reg;

    logic [1:0]   k;
    logic [1:0]   prev;
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  prod_next;
    logic [6:0]   off;
    logic [127:0] acc_next;
    logic [127:0] mask;
    logic [63:0]  magp;
    logic [63:0]  mag;
    logic         over;

    always_comb
    begin
        k         = ph_reg[1:0];
        prev      = 2'(ph_reg - 3'd1);
        a_half    = k[1] ? ua_reg[63:32] : ua_reg[31:0];
        b_half    = k[0] ? ub_reg[63:32] : ub_reg[31:0];
        prod_next = {32'd0, a_half} * {32'd0, b_half};
        off       = {prev[1] & prev[0], prev[1] ^ prev[0], 5'd0};
        acc_next  = acc_reg + ({64'd0, prod_reg} << off);
        mask      = (128'd1 << sh_reg) - 128'd1;
        over      = (|q_reg[127:64]) || (q_reg[63:0] > odo_pkg::LIM62);
        magp      = q_reg[63:0] + {63'd0, neg_reg & rem_reg};
        if (over || magp > odo_pkg::LIM62)
        begin
            mag = odo_pkg::LIM62;
        end
        else
        begin
            mag = magp;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg   <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                ua_reg   <= req.a[63] ? (~req.a + 64'd1) : req.a;
                ub_reg   <= req.b[63] ? (~req.b + 64'd1) : req.b;
                neg_reg  <= req.a[63] ^ req.b[63];
                sh_reg   <= req.sh;
                acc_reg  <= 128'd0;
                busy_reg <= 1'b1;
                ph_reg   <= 3'd0;
            end
            else if (busy_reg)
            begin
                ph_reg <= ph_reg + 3'd1;
                if (ph_reg < PH_ACC_LAST)
                begin
                    prod_reg <= prod_next;
                    if (ph_reg != 3'd0)
                    begin
                        acc_reg <= acc_next;
                    end
                end
                else if (ph_reg == PH_ACC_LAST)
                begin
                    acc_reg <= acc_next;
                end
                else if (ph_reg == PH_SHIFT)
                begin
                    q_reg   <= acc_reg >> sh_reg;
                    rem_reg <= |(acc_reg & mask);
                end
                else if (ph_reg == PH_FIN)
                begin
                    res_reg  <= neg_reg ? (~mag + 64'd1) : mag;
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* src/odo_back.sv */
// odo_back: sequencer for distance, heading, CORDIC pose update, speeds, accelerations and speed product.
// Drives the shared odo_mul unit; depends on odo_pkg.
`default_nettype none

module odo_back #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_valid,
    input  odo_pkg::delta_t   q_item,
    output logic              q_pop,
    input  wire logic [31:0]  meters_per_tick,
    input  wire logic [23:0]  inv_track_width,
    input  wire logic [27:0]  inv_period,
    output odo_pkg::mul_req_t mul_req,
    input  odo_pkg::mul_rsp_t mul_rsp,
    output logic              out_valid,
    input  wire logic         out_ready,
    output odo_pkg::result_t  out_data
);

    localparam int NSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int CW     = $clog2(NSTEPS);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MD    = 4'd1;
    localparam logic [3:0] ST_MDIFF = 4'd2;
    localparam logic [3:0] ST_MDT   = 4'd3;
    localparam logic [3:0] ST_WRAP  = 4'd4;
    localparam logic [3:0] ST_CORD  = 4'd5;
    localparam logic [3:0] ST_MPX   = 4'd6;
    localparam logic [3:0] ST_MPY   = 4'd7;
    localparam logic [3:0] ST_MLIN  = 4'd8;
    localparam logic [3:0] ST_MANG  = 4'd9;
    localparam logic [3:0] ST_MPROD = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0]         state_reg;
    logic               issued_reg;
    logic               out_valid_reg;
    logic [CW-1:0]      cnt_reg;
    logic signed [31:0] dl_reg;
    logic signed [31:0] dr_reg;
    logic signed [63:0] d_reg;
    logic signed [63:0] diff_reg;
    logic signed [31:0] dt_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [33:0] z_reg;
    logic               flip_reg;
    logic signed [31:0] theta_reg;
    logic signed [31:0] xpos_reg;
    logic signed [31:0] ypos_reg;
    logic signed [31:0] lin_reg;
    logic signed [31:0] ang_reg;
    logic signed [31:0] prod_reg;
    logic signed [31:0] prev_lin_reg;
    logic signed [31:0] prev_ang_reg;
    odo_pkg::result_t   out_reg;

    logic               is_mul;
    logic signed [32:0] sum33;
    logic signed [32:0] dif33;
    logic signed [33:0] c_val;
    logic signed [33:0] s_val;
    logic signed [35:0] theta36;
    logic signed [35:0] dt36;
    logic signed [35:0] mida;
    logic signed [35:0] fold;
    logic               fold_flip;
    logic signed [33:0] x_sh;
    logic signed [33:0] y_sh;
    logic signed [33:0] atan_v;
    logic signed [65:0] res66;
    logic               out_load;

    always_comb
    begin
        sum33   = {dl_reg[31], dl_reg} + {dr_reg[31], dr_reg};
        dif33   = {dr_reg[31], dr_reg} - {dl_reg[31], dl_reg};
        c_val   = flip_reg ? -x_reg : x_reg;
        s_val   = flip_reg ? -y_reg : y_reg;
        theta36 = {{4{theta_reg[31]}}, theta_reg};
        dt36    = {{4{dt_reg[31]}}, dt_reg};
        mida    = {{4{1'b0}}, 32'd0};
        mida    = 36'(odo_pkg::wrap_angle(theta36 + (dt36 >>> 1)));
        mida    = {{4{mida[31]}}, mida[31:0]};
        if (mida > odo_pkg::HALF_PI_Q28)
        begin
            fold      = mida - odo_pkg::PI_Q28;
            fold_flip = 1'b1;
        end
        else if (mida < -odo_pkg::HALF_PI_Q28)
        begin
            fold      = mida + odo_pkg::PI_Q28;
            fold_flip = 1'b1;
        end
        else
        begin
            fold      = mida;
            fold_flip = 1'b0;
        end
        x_sh   = x_reg >>> cnt_reg;
        y_sh   = y_reg >>> cnt_reg;
        atan_v = {2'b00, odo_pkg::atan_q30(5'(cnt_reg))};
        res66  = {{2{mul_rsp.res[63]}}, mul_rsp.res};
    end

    always_comb
    begin
        is_mul      = 1'b1;
        mul_req.a   = 64'sd0;
        mul_req.b   = 64'sd0;
        mul_req.sh  = 6'd0;
        unique case (state_reg)
            ST_MD:
            begin
                mul_req.a  = {{31{sum33[32]}}, sum33};
                mul_req.b  = {32'd0, meters_per_tick};
                mul_req.sh = 6'd1;
            end
            ST_MDIFF:
            begin
                mul_req.a  = {{31{dif33[32]}}, dif33};
                mul_req.b  = {32'd0, meters_per_tick};
            end
            ST_MDT:
            begin
                mul_req.a  = diff_reg;
                mul_req.b  = {40'd0, inv_track_width};
                mul_req.sh = 6'd20;
            end
            ST_MPX:
            begin
                mul_req.a  = d_reg;
                mul_req.b  = {{30{c_val[33]}}, c_val};
                mul_req.sh = 6'd46;
            end
            ST_MPY:
            begin
                mul_req.a  = d_reg;
                mul_req.b  = {{30{s_val[33]}}, s_val};
                mul_req.sh = 6'd46;
            end
            ST_MLIN:
            begin
                mul_req.a  = d_reg;
                mul_req.b  = {36'd0, inv_period};
                mul_req.sh = 6'd32;
            end
            ST_MANG:
            begin
                mul_req.a  = {{32{dt_reg[31]}}, dt_reg};
                mul_req.b  = {36'd0, inv_period};
                mul_req.sh = 6'd28;
            end
            ST_MPROD:
            begin
                mul_req.a  = {{32{lin_reg[31]}}, lin_reg};
                mul_req.b  = {{32{ang_reg[31]}}, ang_reg};
                mul_req.sh = 6'd16;
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
        mul_req.start = is_mul && !issued_reg;
    end

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            dl_reg <= q_item.dl;
            dr_reg <= q_item.dr;
        end
        if (mul_rsp.done)
        begin
            unique case (state_reg)
                ST_MD:    d_reg    <= mul_rsp.res;
                ST_MDIFF: diff_reg <= mul_rsp.res;
                ST_MDT:   dt_reg   <= odo_pkg::sat32(res66);
                ST_MLIN:  lin_reg  <= odo_pkg::sat32(res66);
                ST_MANG:  ang_reg  <= odo_pkg::sat32(res66);
                ST_MPROD: prod_reg <= odo_pkg::sat32(res66);
                default:  ;
            endcase
        end
        if (state_reg == ST_WRAP)
        begin
            x_reg    <= odo_pkg::CORDIC_GAIN_Q30;
            y_reg    <= 34'sd0;
            z_reg    <= 34'(fold <<< 2);
            flip_reg <= fold_flip;
        end
        else if (state_reg == ST_CORD)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_v;
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_v;
            end
        end
        if (out_load)
        begin
            out_reg.pos_x         <= xpos_reg;
            out_reg.pos_y         <= ypos_reg;
            out_reg.heading       <= theta_reg[30:0];
            out_reg.lin_speed     <= lin_reg;
            out_reg.ang_speed     <= ang_reg;
            out_reg.lin_accel     <= odo_pkg::sat32({{34{lin_reg[31]}}, lin_reg}
                                     - {{34{prev_lin_reg[31]}}, prev_lin_reg});
            out_reg.ang_accel     <= odo_pkg::sat32({{34{ang_reg[31]}}, ang_reg}
                                     - {{34{prev_ang_reg[31]}}, prev_ang_reg});
            out_reg.speed_product <= prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            theta_reg     <= 32'sd0;
            xpos_reg      <= 32'sd0;
            ypos_reg      <= 32'sd0;
            prev_lin_reg  <= 32'sd0;
            prev_ang_reg  <= 32'sd0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (is_mul)
            begin
                if (mul_rsp.done)
                begin
                    issued_reg <= 1'b0;
                    unique case (state_reg)
                        ST_MD:    state_reg <= ST_MDIFF;
                        ST_MDIFF: state_reg <= ST_MDT;
                        ST_MDT:   state_reg <= ST_WRAP;
                        ST_MPX:
                        begin
                            xpos_reg  <= odo_pkg::sat32({{34{xpos_reg[31]}}, xpos_reg}
                                                        + res66);
                            state_reg <= ST_MPY;
                        end
                        ST_MPY:
                        begin
                            ypos_reg  <= odo_pkg::sat32({{34{ypos_reg[31]}}, ypos_reg}
                                                        + res66);
                            state_reg <= ST_MLIN;
                        end
                        ST_MLIN:  state_reg <= ST_MANG;
                        ST_MANG:  state_reg <= ST_MPROD;
                        default:  state_reg <= ST_OUT;
                    endcase
                end
                else if (!issued_reg)
                begin
                    issued_reg <= 1'b1;
                end
            end
            else
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                        if (q_valid)
                        begin
                            state_reg <= ST_MD;
                        end
                    end
                    ST_WRAP:
                    begin
                        theta_reg <= odo_pkg::wrap_angle(theta36 + dt36);
                        cnt_reg   <= '0;
                        state_reg <= ST_CORD;
                    end
                    ST_CORD:
                    begin
                        if (cnt_reg == CW'(NSTEPS - 1))
                        begin
                            state_reg <= ST_MPX;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    ST_OUT:
                    begin
                        if (out_load)
                        begin
                            prev_lin_reg <= lin_reg;
                            prev_ang_reg <= ang_reg;
                            state_reg    <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

/* src/differential_drive_odometry_core.sv */
// differential_drive_odometry_core: top level of the odometry block.
// Instantiates odo_front, odo_queue, odo_back and odo_mul; depends on odo_pkg.
//
//  channel   | direction | handshake               | payload
//  s_axis    | in        | s_axis_tvalid/tready    | left/right counts
//  m_axis    | out       | m_axis_tvalid/tready    | pose, speeds, accels, product
//  cfg       | in        | cfg_we                  | cfg_index, cfg_wdata
//
// In the back part each request runs eight products through the single shared
// multiplier (four 32x32 partial products, shift and clamp each) plus one CORDIC
// iteration per cycle.
// The front takes a request per cycle while the two-entry queue has room.
// Reset is asynchronous, active low; pose, last counts and previous speeds clear to zero.
// A result waits in the output register while the back moves on to the next request.
`default_nettype none

module differential_drive_odometry_core #(
    parameter int CORDIC_STEPS = 24
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,  // left_count[31:0], right_count[63:32]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_x[31:0], pos_y[63:32], heading[94:64], lin_speed[126:95],
    // ang_speed[158:127], lin_accel[190:159], ang_accel[222:191],
    // speed_product[254:223], zero[255]
    output logic [255:0]      m_axis_tdata,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata
);

    logic [31:0] mpt_reg;
    logic [23:0] itw_reg;
    logic [27:0] ip_reg;

    logic              q_full;
    logic              push;
    odo_pkg::delta_t   push_item;
    logic              pop;
    odo_pkg::delta_t   pop_item;
    logic              q_not_empty;
    odo_pkg::mul_req_t mul_req;
    odo_pkg::mul_rsp_t mul_rsp;
    odo_pkg::result_t  res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mpt_reg <= odo_pkg::MPT_RST;
            itw_reg <= odo_pkg::ITW_RST;
            ip_reg  <= odo_pkg::IP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                odo_pkg::CFG_MPT: mpt_reg <= cfg_wdata;
                odo_pkg::CFG_ITW: itw_reg <= cfg_wdata[23:0];
                odo_pkg::CFG_IP:  ip_reg  <= cfg_wdata[27:0];
                default: ;
            endcase
        end
    end

    odo_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .left_count  (s_axis_tdata[31:0]),
        .right_count (s_axis_tdata[63:32]),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    odo_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (q_not_empty)
    );

    odo_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_not_empty),
        .q_item          (pop_item),
        .q_pop           (pop),
        .meters_per_tick (mpt_reg),
        .inv_track_width (itw_reg),
        .inv_period      (ip_reg),
        .mul_req         (mul_req),
        .mul_rsp         (mul_rsp),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_data        (res)
    );

    odo_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign m_axis_tdata = {1'b0, res};

    a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_rsp.busy && !mul_rsp.done)
        else $error("multiplier started while busy");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[94:64]) >= -odo_pkg::PI_Q28)
                       && ($signed(m_axis_tdata[94:64]) < odo_pkg::PI_Q28))
        else $error("heading outside [-pi, pi)");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_not_empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

/* tb/odometry_checker.sv */
// odometry_checker: watches the request and result streams of the odometry core,
// predicts each pose/speed result and compares it field by field.
// Depends on odo_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module odometry_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [255:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    output int           failures,
    output int           pending
);

    localparam int STEPS = 24;
    localparam longint PI28 = 843314857;
    localparam longint HPI28 = 421657428;

    logic [255:0] pose_queue[$];

    logic [31:0] mpt;
    logic [23:0] itw;
    logic [27:0] ipd;
    logic [31:0] prev_left, prev_right;
    longint px, py, hd, plin, pang;

    function automatic longint atan_entry(int i);
        longint tbl[32] = '{
            'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
            'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
            'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
            'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
            'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
            'h00000001, 'h00000000};
        return tbl[i];
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor(a*b / 2^s), magnitude clamped to 2^62
    function automatic longint scaled_product(longint a, longint b, int s);
        logic signed [129:0] p;
        logic signed [129:0] q;
        logic signed [129:0] lim;
        p = 130'(signed'(a)) * 130'(signed'(b));
        q = p >>> s;
        lim = 130'sd1 <<< 62;
        if (q > lim) q = lim;
        if (q < -lim) q = -lim;
        return longint'(q);
    endfunction

    function automatic longint wrap_pi(longint v);
        longint r;
        r = (v + PI28) % (2 * PI28);
        if (r < 0) r += 2 * PI28;
        return r - PI28;
    endfunction

    function automatic longint tick_delta(logic [31:0] now, logic [31:0] last);
        logic [31:0] d;
        d = now - last;
        return longint'(signed'(d));
    endfunction

    task automatic rotate(input longint ang, output longint c, output longint s);
        longint x, y, z, t;
        bit flip;
        x = 652032874;
        y = 0;
        flip = 0;
        if (ang > HPI28)
        begin
            ang -= PI28;
            flip = 1;
        end
        else if (ang < -HPI28)
        begin
            ang += PI28;
            flip = 1;
        end
        z = ang * 4;
        for (int i = 0; i < STEPS && i < 32; i++)
        begin
            t = x;
            if (z >= 0)
            begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                z -= atan_entry(i);
            end
            else
            begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                z += atan_entry(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_pose(input logic [63:0] counts);
        longint dl, dr, d, diff, dt, mida, c, s, lin, ang;
        logic [255:0] r;
        dl = tick_delta(counts[31:0], prev_left);
        dr = tick_delta(counts[63:32], prev_right);
        d = scaled_product(dl + dr, longint'(mpt), 1);
        diff = scaled_product(dr - dl, longint'(mpt), 0);
        dt = clamp32(scaled_product(diff, longint'(itw), 20));
        prev_left = counts[31:0];
        prev_right = counts[63:32];
        mida = wrap_pi(hd + (dt >>> 1));
        rotate(mida, c, s);
        px = clamp32(px + scaled_product(d, c, 46));
        py = clamp32(py + scaled_product(d, s, 46));
        hd = wrap_pi(hd + dt);
        lin = clamp32(scaled_product(d, longint'(ipd), 32));
        ang = clamp32(scaled_product(dt, longint'(ipd), 28));
        r = '0;
        r[31:0] = px[31:0];
        r[63:32] = py[31:0];
        r[94:64] = hd[30:0];
        r[126:95] = lin[31:0];
        r[158:127] = ang[31:0];
        r[190:159] = 32'(clamp32(lin - plin));
        r[222:191] = 32'(clamp32(ang - pang));
        r[254:223] = 32'(clamp32(scaled_product(lin, ang, 16)));
        plin = lin;
        pang = ang;
        pose_queue.push_back(r);
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h actual %h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [255:0] w;
        if (!rst_n)
        begin
            mpt = odo_pkg::MPT_RST;
            itw = odo_pkg::ITW_RST;
            ipd = odo_pkg::IP_RST;
            prev_left = '0;
            prev_right = '0;
            px = 0; py = 0; hd = 0; plin = 0; pang = 0;
            pose_queue.delete();
            failures = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    odo_pkg::CFG_MPT: mpt = cfg_wdata;
                    odo_pkg::CFG_ITW: itw = cfg_wdata[23:0];
                    odo_pkg::CFG_IP:  ipd = cfg_wdata[27:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pose_queue.size() == 0)
                begin
                    $error("result with no request outstanding");
                    failures++;
                end
                else
                begin
                    w = pose_queue.pop_front();
                    compare_field("pos_x", w[31:0], m_axis_tdata[31:0]);
                    compare_field("pos_y", w[63:32], m_axis_tdata[63:32]);
                    compare_field("heading", {1'b0, w[94:64]},
                                  {1'b0, m_axis_tdata[94:64]});
                    compare_field("lin_speed", w[126:95], m_axis_tdata[126:95]);
                    compare_field("ang_speed", w[158:127], m_axis_tdata[158:127]);
                    compare_field("lin_accel", w[190:159], m_axis_tdata[190:159]);
                    compare_field("ang_accel", w[222:191], m_axis_tdata[222:191]);
                    compare_field("speed_product", w[254:223], m_axis_tdata[254:223]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_pose(s_axis_tdata);
            pending = pose_queue.size();
        end
    end
endmodule

/* tb/testbench.sv */
// testbench: drives encoder-count requests and register writes into the
// odometry core; odometry_checker predicts and compares. Depends on odo_pkg.
`timescale 1ns / 1ps

module testbench;

    logic clk, rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready;
    logic [255:0] m_axis_tdata;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_wdata;
    int failures, pending;
    int send_idle, recv_idle;
    longint cycles;
    logic [31:0] left_pos, right_pos;

    differential_drive_odometry_core dut (.*);

    odometry_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // receiver stalls
    initial
    begin
        m_axis_tready = 0;
        forever
        begin
            @(negedge clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // tvalid stays up after a request until the next one or an idle cycle
    task automatic send_counts(logic [31:0] l, logic [31:0] r);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {r, l};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
        @(negedge clk);
    endtask

    // mostly smooth motion, some wild jumps
    task automatic random_motion(int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    left_pos = $urandom;
                    right_pos = $urandom;
                end
                1:
                begin
                    left_pos += $urandom_range(40000) - 20000;
                    right_pos += $urandom_range(40000) - 20000;
                end
                default:
                begin
                    left_pos += $urandom_range(600) - 300;
                    right_pos += $urandom_range(600) - 300;
                end
            endcase
            send_counts(left_pos, right_pos);
        end
    endtask

    initial
    begin
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        cfg_we = 0;
        cfg_index = odo_pkg::CFG_MPT;
        cfg_wdata = '0;
        send_idle = 24;
        recv_idle = 62;
        left_pos = 0;
        right_pos = 0;
        rst_n = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, huge turns, fold past pi/2, wrap
        send_counts(32'h0, 32'h0);
        send_counts(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_counts(32'h8000_0000, 32'h8000_0000);
        send_counts(32'h8000_0000, 32'h7FFF_FFFF);
        send_counts(32'hFFFF_FFFF, 32'h0000_0001);
        send_counts(32'h0000_0000, 32'h8000_0000);
        send_counts(32'h0000_1000, 32'h0000_5000);
        send_counts(32'h0000_1000, 32'h0001_5000);
        send_counts(32'h0002_1000, 32'h0001_5000);
        send_counts(32'hFFFF_0000, 32'h0000_FFFF);
        send_counts(32'hAAAA_AAAA, 32'h5555_5555);
        send_counts(32'h5555_5555, 32'hAAAA_AAAA);
        left_pos = 32'h5555_5555;
        right_pos = 32'hAAAA_AAAA;
        drain();
        write_reg(odo_pkg::CFG_MPT, 32'hFFFF_FFFF);
        write_reg(odo_pkg::CFG_ITW, 32'h00FF_FFFF);
        write_reg(odo_pkg::CFG_IP, 32'h0FFF_FFFF);
        send_counts(32'h7000_0000, 32'h1000_0000);
        send_counts(32'h0000_0000, 32'h0000_0000);
        send_counts(32'h1234_5678, 32'h8765_4321);
        left_pos = 32'h1234_5678;
        right_pos = 32'h8765_4321;
        random_motion(150);
        drain();
        write_reg(odo_pkg::CFG_MPT, 32'h0);
        write_reg(odo_pkg::CFG_ITW, 32'h0);
        write_reg(odo_pkg::CFG_IP, 32'h0);
        random_motion(100);
        drain();
        write_reg(odo_pkg::CFG_MPT, odo_pkg::MPT_RST);
        write_reg(odo_pkg::CFG_ITW, 32'(odo_pkg::ITW_RST));
        write_reg(odo_pkg::CFG_IP, 32'(odo_pkg::IP_RST));
        random_motion(500);

        drain();
        send_idle = 62;
        recv_idle = 24;
        write_reg(odo_pkg::CFG_MPT, $urandom);
        write_reg(odo_pkg::CFG_ITW, $urandom & 32'h00FF_FFFF);
        write_reg(odo_pkg::CFG_IP, $urandom & 32'h0FFF_FFFF);
        random_motion(500);

        drain();
        send_idle = 0;
        recv_idle = 0;
        write_reg(odo_pkg::CFG_MPT, 32'd4294967);
        write_reg(odo_pkg::CFG_ITW, 32'd65536);
        write_reg(odo_pkg::CFG_IP, 32'd65536000);
        random_motion(585);

        drain();
        if (failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule

/* differential_drive_odometry_core.f */
src/odo_pkg.sv
src/odo_queue.sv
src/odo_front.sv
src/odo_mul.sv
src/odo_back.sv
src/differential_drive_odometry_core.sv
tb/odometry_checker.sv
tb/testbench.sv
